// File: rtl/lotarb_pkg.sv
package lotarb_pkg;

    // Item codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // 31-bit LCG: s' = (s * LCG_MUL + LCG_ADD) mod 2^31
    localparam int          LCG_W    = 31;
    localparam logic [30:0] LCG_MUL  = 31'd1103515245;
    localparam logic [30:0] LCG_ADD  = 31'd12345;
    localparam logic [30:0] LCG_SEED = 31'd1;

    // Input word
    typedef struct packed {
        logic        cmd;
        logic [3:0]  slot;
        logic [7:0]  ticket_count;
        logic [15:0] eligible_mask;
    } t_in;

    // Output word
    typedef struct packed {
        logic        granted;
        logic [3:0]  grant_slot;
        logic [11:0] drawn_ticket;
    } t_out;

    // Controller -> datapath
    typedef struct packed {
        logic capture;     // input word taken
        logic scan_start;  // rewind slot scan
        logic scan_step;   // advance slot scan
        logic walk;        // scan is the winner walk, not the sum
        logic lcg_mul;     // multiply stage of the generator
        logic lcg_add;     // add stage, also loads the divider
        logic div_step;    // one remainder bit
        logic out_load;    // load output register
    } t_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic total_zero;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// File: rtl/lotarb_ctrl.sv
module lotarb_ctrl
    import lotarb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_is_draw,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_WALK = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_is_draw == CMD_DRAW) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = S_SUM;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SUM: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = i_sts.total_zero ? S_FIN : S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.lcg_mul = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.lcg_add = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    o_cmd.scan_start = 1'b1;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.walk      = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A result never overwrites one that is still waiting
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output loaded while previous word pending");

    // The divider only runs with a nonzero divisor
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_step |-> !i_sts.total_zero)
        else $error("division started with zero ticket sum");

endmodule

// File: rtl/lotarb_dp.sv
module lotarb_dp
    import lotarb_pkg::*;
#(
    parameter int SLOTS        = 16,
    parameter int TICKET_WIDTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int SUM_W = TICKET_WIDTH + IDX_W;

    // Ticket memory with per-entry written flags; unwritten entries read as one
    logic [TICKET_WIDTH-1:0] r_mem [SLOTS];
    logic [SLOTS-1:0]        r_tv;
    logic [TICKET_WIDTH-1:0] r_rd_data;
    logic                    r_rd_tv;
    logic [TICKET_WIDTH-1:0] rd_tkt;

    // Scan pipeline
    logic [IDX_W:0]   r_idx;
    logic             r_v;
    logic             r_e;
    logic [IDX_W-1:0] r_i;
    logic [15:0]      r_mask;
    logic [SLOTS-1:0] elig;
    logic             issue;
    logic [IDX_W-1:0] rd_addr;

    // Arithmetic
    logic [SUM_W-1:0]   r_total;
    logic [SUM_W-1:0]   r_base;
    logic [SUM_W:0]     base_end;
    logic               r_hit;
    logic [IDX_W-1:0]   r_found;
    logic [LCG_W-1:0]   r_lcg;
    logic [LCG_W-1:0]   r_prod;
    logic [LCG_W-1:0]   mul_full;
    logic [LCG_W-1:0]   lcg_next;
    logic [LCG_W-1:0]   r_dvd;
    logic [SUM_W-1:0]   r_rem;
    logic [SUM_W:0]     rem_sh;
    logic [4:0]         r_dcnt;

    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [TICKET_WIDTH-1:0] wr_data;

    logic r_ovalid;
    t_out r_out;

    // Mask bits above 15 do not exist
    for (genvar g = 0; g < SLOTS; g++) begin : g_elig
        if (g < 16) begin : g_in
            assign elig[g] = r_mask[g];
        end else begin : g_out
            assign elig[g] = 1'b0;
        end
    end

    assign wr_en   = i_cmd.capture && (i_in_data.cmd == CMD_LOAD)
                     && (7'(i_in_data.slot) < 7'(SLOTS));
    assign wr_addr = IDX_W'(i_in_data.slot);
    assign wr_data = TICKET_WIDTH'(i_in_data.ticket_count);
    assign issue   = i_cmd.scan_step && (r_idx != (IDX_W + 1)'(SLOTS));
    assign rd_addr = r_idx[IDX_W-1:0];
    assign rd_tkt  = r_rd_tv ? r_rd_data : TICKET_WIDTH'(1);

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_tv   <= r_tv[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= '0;
        end else if (wr_en) begin
            r_tv[wr_addr] <= 1'b1;
        end
    end

    // Slot scan: issue address, then consume the data in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_v <= 1'b0;
        end else if (i_cmd.scan_step) begin
            r_v <= issue;
        end
    end

    assign base_end = {1'b0, r_base} + (SUM_W + 1)'(rd_tkt);

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mask  <= i_in_data.eligible_mask;
            r_hit   <= 1'b0;
            r_found <= '0;
        end
        if (i_cmd.scan_start) begin
            r_idx  <= '0;
            r_base <= '0;
            if (!i_cmd.walk && !i_cmd.div_step) begin
                r_total <= '0;
            end
        end else if (i_cmd.scan_step) begin
            if (issue) begin
                r_idx <= r_idx + (IDX_W + 1)'(1);
                r_e   <= elig[rd_addr];
                r_i   <= rd_addr;
            end
            if (r_v && r_e) begin
                if (i_cmd.walk) begin
                    // winner walk: first eligible slot whose run holds the ticket
                    if (!r_hit && ({1'b0, r_rem} < base_end)) begin
                        r_hit   <= 1'b1;
                        r_found <= r_i;
                    end
                    r_base <= base_end[SUM_W-1:0];
                end else begin
                    r_total <= r_total + SUM_W'(rd_tkt);
                end
            end
        end
    end

    // Generator: multiply (low 31 bits only), register, then add
    assign mul_full = r_lcg * LCG_MUL;
    assign lcg_next = r_prod + LCG_ADD;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lcg_mul) begin
            r_prod <= mul_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcg <= LCG_SEED;
        end else if (i_cmd.lcg_add) begin
            r_lcg <= lcg_next;
        end
    end

    // Restoring remainder, one dividend bit a cycle
    assign rem_sh = {r_rem, r_dvd[LCG_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.lcg_add) begin
            r_dvd  <= lcg_next;
            r_rem  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_total}) begin
                r_rem <= SUM_W'(rem_sh - {1'b0, r_total});
            end else begin
                r_rem <= rem_sh[SUM_W-1:0];
            end
            r_dvd  <= r_dvd << 1;
            r_dcnt <= r_dcnt + 5'd1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.granted      <= r_hit;
            r_out.grant_slot   <= r_hit ? 4'(r_found) : 4'd0;
            r_out.drawn_ticket <= r_hit ? 12'(r_rem) : 12'd0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    assign o_sts.scan_done  = (r_idx == (IDX_W + 1)'(SLOTS)) && !r_v;
    assign o_sts.total_zero = (r_total == '0);
    assign o_sts.div_last   = (r_dcnt == 5'd30);
    assign o_sts.out_free   = !r_ovalid || i_out_ready;

    // The drawn ticket lies below the sum during the walk
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_step && i_cmd.walk) |-> (r_rem < r_total))
        else $error("winning ticket not below ticket sum");

    // A finished walk always finds a winner
    a_walk_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && o_sts.scan_done) |-> r_hit)
        else $error("walk finished without a winner");

endmodule

// File: rtl/lottery_arbiter_lcg.sv
// Lottery arbiter with a 31-bit LCG.
// Input channel (i_in_valid / o_in_ready / i_in_data): one word per item.
//   cmd = load writes ticket_count to slot and returns an all-zero result.
//   cmd = draw sums the tickets of the slots in eligible_mask, advances the
//   generator, takes its value modulo the sum and grants the first eligible
//   slot whose ticket run holds it. A zero sum returns an all-zero result
//   and leaves the generator unchanged.
// Output channel (o_out_valid / i_out_ready / o_out_data): one word per item.
// A draw makes two slot scans through the ticket memory port, one multiply
//   and one add for the generator, and a bit-serial remainder over the
//   31-bit generator value. A zero-sum draw ends after the first scan.
// One item is worked on at a time; o_in_ready is high whenever the block is
//   idle, even while a finished result waits in the output register.
// If the receiver stalls, the result holds and the next item finishes its
//   work, then waits for the output register to empty.
// Reset: every slot holds one ticket, the generator holds 1, no output valid.
module lottery_arbiter_lcg
    import lotarb_pkg::*;
#(
    parameter int SLOTS        = 16,
    parameter int TICKET_WIDTH = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    lotarb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_is_draw  (i_in_data.cmd),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lotarb_dp #(
        .SLOTS        (SLOTS),
        .TICKET_WIDTH (TICKET_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
